@@ rtl/core/idl_pkg.sv @@
// ----------------------------------------------------------------------------
// idl_pkg
// Shared widths, request codes and defaults for the indexed deque list.
// ----------------------------------------------------------------------------
`default_nettype none

package idl_pkg;

	localparam int KindW        = 4;
	localparam int PosW         = 4;
	localparam int WordW        = 32;
	localparam int CountW       = 5;
	localparam int DefCapacity  = 16;

	typedef enum logic [KindW-1:0] {
		KIND_PUSH_BACK    = 4'd0,
		KIND_PUSH_FRONT   = 4'd1,
		KIND_GET          = 4'd2,
		KIND_REMOVE_FRONT = 4'd3,
		KIND_REMOVE_BACK  = 4'd4,
		KIND_REMOVE_AT    = 4'd5,
		KIND_INSERT_AT    = 4'd6,
		KIND_CLEAR        = 4'd7,
		KIND_LENGTH       = 4'd8
	} kind_t;

endpackage

`default_nettype wire

@@ rtl/core/idl_req_if.sv @@
// ----------------------------------------------------------------------------
// idl_req_if
// Request channel of the indexed deque list: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface idl_req_if;

	logic                        valid;
	logic                        ready;
	logic [idl_pkg::KindW-1:0]   kind;
	logic [idl_pkg::PosW-1:0]    position;
	logic [idl_pkg::WordW-1:0]   value_in;

	modport source (output valid, output kind, output position, output value_in,
		input ready);
	modport sink (input valid, input kind, input position, input value_in,
		output ready);

endinterface

`default_nettype wire

@@ rtl/core/idl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// idl_rsp_if
// Response channel of the indexed deque list: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface idl_rsp_if;

	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic [idl_pkg::WordW-1:0]   value_out;
	logic [idl_pkg::CountW-1:0]  count;

	modport source (output valid, output ok, output value_out, output count,
		input ready);
	modport sink (input valid, input ok, input value_out, input count,
		output ready);

endinterface

`default_nettype wire

@@ rtl/core/indexed_deque_list.sv @@
// push_back, remove_back, clear, length and refused requests go straight to
// the response state; get first reads the entry; push_front, insert_at,
// remove_front and remove_at first move entries, each move one read then one
// write on the storage array. Ready is high only when idle, so a new request
// waits until the last is answered; a held response stalls that on rsp.ready.
// Reset clears the count and the control state; storage is not cleared.
// ----------------------------------------------------------------------------
// indexed_deque_list
// Ordered list of words in a RAM with indexed insert/remove by entry moves.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_deque_list #(
	parameter int CAPACITY = idl_pkg::DefCapacity
) (
	input  wire        clk,
	input  wire        arst_n,
	idl_req_if.sink    req,
	idl_rsp_if.source  rsp
);
	import idl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = (CW > PosW) ? CW : PosW;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_UP_RD = 7'b0000010,
		ST_UP_WR = 7'b0000100,
		ST_DN_RD = 7'b0001000,
		ST_DN_WR = 7'b0010000,
		ST_GET   = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [WordW-1:0] val_q, val_d;
	logic [WordW-1:0] data_q, data_d;
	logic ok_q, ok_d;

	logic [WordW-1:0] mem_q [CAPACITY];
	logic [WordW-1:0] rd_q;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [WordW-1:0] mem_wd;

	logic rsp_v_q, rsp_ok_q, load_rsp;
	logic [WordW-1:0] rsp_value_q;
	logic [CountW-1:0] rsp_count_q;

	logic full, pos_ok;

	assign full   = (cnt_q == CW'(CAPACITY));
	assign pos_ok = (PW'(req.position) < PW'(cnt_q));

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_v_q;
	assign rsp.ok        = rsp_ok_q;
	assign rsp.value_out = rsp_value_q;
	assign rsp.count     = rsp_count_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		lo_d     = lo_q;
		val_d    = val_q;
		data_d   = data_q;
		ok_d     = ok_q;
		mem_we   = 1'b0;
		mem_wa   = AW'(cnt_q);
		mem_wd   = req.value_in;
		mem_ra   = AW'(req.position);
		load_rsp = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					val_d   = req.value_in;
					data_d  = '0;
					ok_d    = 1'b0;
					state_d = ST_RESP;
					unique case (req.kind)
						KIND_PUSH_BACK: begin
							if (!full) begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CW'(1);
								ok_d   = 1'b1;
							end
						end
						KIND_PUSH_FRONT: begin
							if (!full) begin
								ok_d    = 1'b1;
								lo_d    = '0;
								ptr_d   = cnt_q;
								state_d = ST_UP_RD;
							end
						end
						KIND_INSERT_AT: begin
							if (!full && pos_ok) begin
								ok_d    = 1'b1;
								lo_d    = CW'(req.position);
								ptr_d   = cnt_q;
								state_d = ST_UP_RD;
							end
						end
						KIND_GET: begin
							if (pos_ok) begin
								ok_d    = 1'b1;
								state_d = ST_GET;
							end
						end
						KIND_REMOVE_FRONT: begin
							if (cnt_q != '0) begin
								ok_d    = 1'b1;
								ptr_d   = CW'(1);
								state_d = ST_DN_RD;
							end
						end
						KIND_REMOVE_BACK: begin
							if (cnt_q != '0) begin
								ok_d  = 1'b1;
								cnt_d = cnt_q - CW'(1);
							end
						end
						KIND_REMOVE_AT: begin
							if (pos_ok) begin
								ok_d    = 1'b1;
								ptr_d   = CW'(req.position) + CW'(1);
								state_d = ST_DN_RD;
							end
						end
						KIND_CLEAR: begin
							ok_d  = 1'b1;
							cnt_d = '0;
						end
						KIND_LENGTH: ok_d = 1'b1;
						default: ok_d = 1'b0;
					endcase
				end
			end
			// open a gap: ptr is the destination, walking down to lo
			ST_UP_RD: begin
				if (ptr_q == lo_q) begin
					mem_we  = 1'b1;
					mem_wa  = AW'(lo_q);
					mem_wd  = val_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = ST_RESP;
				end else begin
					mem_ra  = AW'(ptr_q - CW'(1));
					state_d = ST_UP_WR;
				end
			end
			ST_UP_WR: begin
				mem_we  = 1'b1;
				mem_wa  = AW'(ptr_q);
				mem_wd  = rd_q;
				ptr_d   = ptr_q - CW'(1);
				state_d = ST_UP_RD;
			end
			// close a gap: ptr is the source, walking up to count
			ST_DN_RD: begin
				if (ptr_q == cnt_q) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = ST_RESP;
				end else begin
					mem_ra  = AW'(ptr_q);
					state_d = ST_DN_WR;
				end
			end
			ST_DN_WR: begin
				mem_we  = 1'b1;
				mem_wa  = AW'(ptr_q - CW'(1));
				mem_wd  = rd_q;
				ptr_d   = ptr_q + CW'(1);
				state_d = ST_DN_RD;
			end
			ST_GET: begin
				data_d  = rd_q;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_v_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// storage: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_rsp) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		lo_q   <= lo_d;
		val_q  <= val_d;
		data_q <= data_d;
		ok_q   <= ok_d;
		if (load_rsp) begin
			rsp_ok_q    <= ok_q;
			rsp_value_q <= data_q;
			rsp_count_q <= CountW'(cnt_q);
		end
	end

endmodule

`default_nettype wire
